// File: src/tpvs_pkg.sv
package tpvs_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  // phase codes
  localparam logic [2:0] PH_PAUSE    = 3'd0;
  localparam logic [2:0] PH_FADE_IN  = 3'd1;
  localparam logic [2:0] PH_VACUUM   = 3'd2;
  localparam logic [2:0] PH_HOLD     = 3'd3;
  localparam logic [2:0] PH_FADE_OUT = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_LIGHTING = 3'd0;
  localparam logic [2:0] REG_FADE_IN  = 3'd1;
  localparam logic [2:0] REG_FADE_OUT = 3'd2;
  localparam logic [2:0] REG_SHOW     = 3'd3;
  localparam logic [2:0] REG_HOLD     = 3'd4;
  localparam logic [2:0] REG_LEVEL    = 3'd5;

  // timing constants in ms
  localparam logic [31:0] STOP_DELAY_MS = 32'd10;
  localparam logic [31:0] LINGER_MS     = 32'd2000;

  // sequencer state
  typedef struct packed {
    logic        start_pending;
    logic        running;
    logic [31:0] fade_in_done;
    logic [31:0] vacuum_end;
    logic [31:0] hold_end;
    logic [31:0] finish;
  } seq_state_t;

  // deadline offsets relative to launch / stop time, folded from config
  typedef struct packed {
    logic [31:0] off_fade_in;
    logic [31:0] off_vacuum;
    logic [31:0] off_hold;
    logic [31:0] off_finish;
    logic [31:0] off_stop_fin;
    logic [15:0] level;
  } seq_cfg_t;

  // one result beat
  typedef struct packed {
    logic        pump_enabled;
    logic        valve_open;
    logic        apply_light_target;
    logic [15:0] light_target_level;
    logic        light_until_valid;
    logic [31:0] light_on_until;
    logic        stop_accepted;
    logic [2:0]  phase;
  } seq_res_t;

endpackage

// File: src/tpvs_step.sv
module tpvs_step import tpvs_pkg::*; (
  input  logic [1:0]  cmd_i,
  input  logic [31:0] now_ms_i,
  input  seq_state_t  state_i,
  input  seq_cfg_t    cfg_i,
  output seq_state_t  state_o,
  output seq_res_t    res_o
);

  logic [31:0] fade_in_at;
  logic [31:0] vacuum_at;
  logic [31:0] hold_at;
  logic [31:0] finish_at;
  logic [31:0] stop_at;
  logic [31:0] stop_fin_at;
  logic [31:0] since_finish;
  seq_state_t  st;
  seq_res_t    res;

  // candidate deadlines; offsets precomputed from config, the stop delay is a constant
  assign fade_in_at  = now_ms_i + cfg_i.off_fade_in;
  assign vacuum_at   = now_ms_i + cfg_i.off_vacuum;
  assign hold_at     = now_ms_i + cfg_i.off_hold;
  assign finish_at   = now_ms_i + cfg_i.off_finish;
  assign stop_at     = now_ms_i + STOP_DELAY_MS;
  assign stop_fin_at = now_ms_i + cfg_i.off_stop_fin;

  // command decode and state update
  always_comb begin
    st  = state_i;
    res = '0;
    case (cmd_i)
      CMD_TICK: begin
        if (st.start_pending) begin
          st.fade_in_done           = fade_in_at;
          st.vacuum_end             = vacuum_at;
          st.hold_end               = hold_at;
          st.finish                 = finish_at;
          st.start_pending          = 1'b0;
          st.running                = 1'b1;
          res.light_until_valid     = 1'b1;
          res.light_on_until        = hold_at;
          res.apply_light_target    = 1'b1;
          res.light_target_level    = cfg_i.level;
        end
        if (st.running) begin
          if (now_ms_i < st.fade_in_done) begin
            res.pump_enabled = 1'b0;
          end else if (now_ms_i < st.vacuum_end) begin
            res.pump_enabled = 1'b1;
            res.valve_open   = 1'b1;
          end else if (now_ms_i < st.hold_end) begin
            res.valve_open   = 1'b1;
          end else if (!(now_ms_i < st.finish)) begin
            st.running       = 1'b0;
          end
        end
      end
      CMD_START: begin
        if (!st.running) begin
          st.start_pending = 1'b1;
        end
      end
      CMD_STOP: begin
        if (st.running) begin
          st.fade_in_done       = stop_at;
          st.vacuum_end         = stop_at;
          st.hold_end           = stop_at;
          st.finish             = stop_fin_at;
          res.light_until_valid = 1'b1;
          res.light_on_until    = stop_at;
          res.stop_accepted     = 1'b1;
        end
      end
      CMD_RESET: begin
        st = '0;
      end
      default: begin
        st = '0;
      end
    endcase
  end

  // phase after this step, judged at now
  assign since_finish = now_ms_i - st.finish;

  always_comb begin
    if (st.running) begin
      if (now_ms_i < st.fade_in_done) begin
        res_o.phase = PH_FADE_IN;
      end else if (now_ms_i < st.vacuum_end) begin
        res_o.phase = PH_VACUUM;
      end else if (now_ms_i < st.hold_end) begin
        res_o.phase = PH_HOLD;
      end else begin
        res_o.phase = PH_FADE_OUT;
      end
    end else if ((st.finish != '0) && (since_finish < LINGER_MS)) begin
      res_o.phase = PH_FADE_OUT;
    end else begin
      res_o.phase = PH_PAUSE;
    end
    res_o.pump_enabled       = res.pump_enabled;
    res_o.valve_open         = res.valve_open;
    res_o.apply_light_target = res.apply_light_target;
    res_o.light_target_level = res.light_target_level;
    res_o.light_until_valid  = res.light_until_valid;
    res_o.light_on_until     = res.light_on_until;
    res_o.stop_accepted      = res.stop_accepted;
  end

  assign state_o = st;

endmodule

// File: src/timed_pump_valve_show_sequencer.sv
// a beat enters the input register, then the result register as the output advances
// throughput: one beat per cycle unless the output stalls; the two registers are parted
//   by one pass of adders and deadline comparators, state is written as a beat leaves
// reset: asynchronous, clears the run state, all config registers and both pipeline
//   valid bits; no clearing pass, the block takes beats right after reset
module timed_pump_valve_show_sequencer import tpvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] now_ms_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pump_enabled_o,
  output logic        valve_open_o,
  output logic        apply_light_target_o,
  output logic [15:0] light_target_level_o,
  output logic        light_until_valid_o,
  output logic [31:0] light_on_until_o,
  output logic        stop_accepted_o,
  output logic [2:0]  phase_o
);

  logic        lighting_q, lighting_d;
  logic [31:0] fade_in_q, fade_in_d;
  logic [31:0] fade_out_q, fade_out_d;
  logic [31:0] show_q, show_d;
  logic [31:0] hold_q, hold_d;
  logic [15:0] level_q, level_d;
  logic [31:0] eff_in_d, eff_out_d;
  seq_cfg_t    cfg_q, cfg_d;

  logic        s1_valid_q;
  logic [1:0]  s1_cmd_q;
  logic [31:0] s1_now_q;
  logic        out_valid_q;
  seq_res_t    res_q;
  seq_state_t  state_q;
  seq_state_t  state_d;
  seq_res_t    res_d;
  logic        advance;

  // config write decode
  always_comb begin
    lighting_d = lighting_q;
    fade_in_d  = fade_in_q;
    fade_out_d = fade_out_q;
    show_d     = show_q;
    hold_d     = hold_q;
    level_d    = level_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LIGHTING: lighting_d = cfg_data_i[0];
        REG_FADE_IN:  fade_in_d  = cfg_data_i;
        REG_FADE_OUT: fade_out_d = cfg_data_i;
        REG_SHOW:     show_d     = cfg_data_i;
        REG_HOLD:     hold_d     = cfg_data_i;
        REG_LEVEL:    level_d    = cfg_data_i[15:0];
        default:      lighting_d = lighting_q;
      endcase
    end
  end

  // fold config into cumulative deadline offsets
  assign eff_in_d  = lighting_d ? fade_in_d  : '0;
  assign eff_out_d = lighting_d ? fade_out_d : '0;

  always_comb begin
    cfg_d.off_fade_in  = eff_in_d;
    cfg_d.off_vacuum   = eff_in_d + show_d;
    cfg_d.off_hold     = cfg_d.off_vacuum + hold_d;
    cfg_d.off_finish   = cfg_d.off_hold + eff_out_d;
    cfg_d.off_stop_fin = STOP_DELAY_MS + eff_out_d;
    cfg_d.level        = level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lighting_q <= 1'b0;
      fade_in_q  <= '0;
      fade_out_q <= '0;
      show_q     <= '0;
      hold_q     <= '0;
      level_q    <= '0;
      cfg_q      <= '{off_fade_in: '0, off_vacuum: '0, off_hold: '0, off_finish: '0,
                      off_stop_fin: STOP_DELAY_MS, level: '0};
    end else begin
      lighting_q <= lighting_d;
      fade_in_q  <= fade_in_d;
      fade_out_q <= fade_out_d;
      show_q     <= show_d;
      hold_q     <= hold_d;
      level_q    <= level_d;
      cfg_q      <= cfg_d;
    end
  end

  // pipeline flow control
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q <= cmd_i;
      s1_now_q <= now_ms_i;
    end
  end

  // step logic
  tpvs_step u_step (
    .cmd_i    (s1_cmd_q),
    .now_ms_i (s1_now_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .res_o    (res_d)
  );

  // run state and result register, updated as a beat moves out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign pump_enabled_o       = res_q.pump_enabled;
  assign valve_open_o         = res_q.valve_open;
  assign apply_light_target_o = res_q.apply_light_target;
  assign light_target_level_o = res_q.light_target_level;
  assign light_until_valid_o  = res_q.light_until_valid;
  assign light_on_until_o     = res_q.light_on_until;
  assign stop_accepted_o      = res_q.stop_accepted;
  assign phase_o              = res_q.phase;

  // input stalls only behind a full, stalled pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  // a launch always reports the new light deadline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && apply_light_target_o) |-> light_until_valid_o)
    else $error("launch without light deadline");

  // pump never runs with the valve closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pump_enabled_o) |-> valve_open_o)
    else $error("pump on with valve closed");

  // a pending start and a running show never coexist
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.start_pending && state_q.running))
    else $error("start pending while running");

  // an accepted stop keeps the show running, with drives off and a light deadline reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stop_accepted_o) |->
      (!pump_enabled_o && !valve_open_o && light_until_valid_o))
    else $error("stop beat with drives on");

endmodule
